### rtl/lld_pkg.sv
package lld_pkg;

   localparam int CMD_W   = 1;
   localparam int AMT_W   = 31;
   localparam int ID_W    = 5;
   localparam int CHOSE_W = 4;
   localparam int OUTL_W  = 32;
   localparam int WC_W    = 5;
   localparam int TDATA_W = 40;

   localparam logic            CMD_DISPATCH = 1'b0;
   localparam logic            CMD_RELEASE  = 1'b1;
   localparam logic            STATUS_OK    = 1'b0;
   localparam logic            STATUS_RANGE = 1'b1;
   localparam logic [WC_W-1:0] WC_RESET     = 5'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FETCH,
      ST_SETTLE,
      ST_UPDATE,
      ST_REPLY
   } lld_state_type;

   typedef struct packed {
      logic capture;
      logic scan_clr;
      logic rd_en;
      logic rd_use_id;
      logic upd_en;
      logic reply_en;
   } lld_cmd_type;

   typedef struct packed {
      logic is_release;
      logic id_neg;
      logic id_range_err;
      logic scan_last;
      logic rsp_busy;
   } lld_sts_type;

endpackage

### rtl/least_loaded_worker_dispatch.sv
// Least-loaded dispatcher: one signed load counter per worker, zero after reset. A dispatch
// (tuser 0) scans the first pool_size counters, picks the smallest (lowest index on a tie),
// adds load_amount with saturation and returns index and new load. A release (tuser 1) subtracts
// load_amount from the worker named by target_id; a negative id is a no-op with status ok, an
// id at or past the pool size returns status 1 and changes nothing. Items are handled one at a
// time. After an item is accepted, a dispatch passes through DECODE, SCAN, SETTLE and UPDATE,
// a valid release through DECODE, FETCH, SETTLE and UPDATE, and a no-op or error through
// DECODE and REPLY; UPDATE and REPLY wait while the result register waits on rsp_tready. The
// scan (pool_size 0 counts as 1, capped at MAX_WORKERS) uses the single comparator, reading
// one table entry per cycle through the one read port of the load table.
module least_loaded_worker_dispatch #(
   parameter int MAX_WORKERS = 16,
   parameter int LOAD_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // load_amount[30:0], target_id[35:31], zero pad
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // chosen_worker[3:0], new_load[35:4], zero pad
   output logic        rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data  // pool_size
);

   lld_pkg::lld_cmd_type cmd;
   lld_pkg::lld_sts_type sts;

   lld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lld_datapath #(
      .MAX_WORKERS (MAX_WORKERS),
      .LOAD_WIDTH  (LOAD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transfer taken while an item is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.upd_en || cmd.reply_en) |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register loaded while a transfer is pending");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("range error result carries a non-zero worker or load");

endmodule

### rtl/lld_ctrl.sv
module lld_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lld_pkg::lld_sts_type sts,
   output lld_pkg::lld_cmd_type cmd
);

   lld_pkg::lld_state_type state_ff;
   lld_pkg::lld_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lld_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = lld_pkg::ST_DECODE;
            end
         end
         lld_pkg::ST_DECODE: begin
            if (!sts.is_release) begin
               state_in = lld_pkg::ST_SCAN;
            end else if (sts.id_neg || sts.id_range_err) begin
               state_in = lld_pkg::ST_REPLY;
            end else begin
               state_in = lld_pkg::ST_FETCH;
            end
         end
         lld_pkg::ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = lld_pkg::ST_SETTLE;
            end
         end
         lld_pkg::ST_FETCH:  state_in = lld_pkg::ST_SETTLE;
         lld_pkg::ST_SETTLE: state_in = lld_pkg::ST_UPDATE;
         lld_pkg::ST_UPDATE: begin
            if (!sts.rsp_busy) begin
               state_in = lld_pkg::ST_IDLE;
            end
         end
         lld_pkg::ST_REPLY: begin
            if (!sts.rsp_busy) begin
               state_in = lld_pkg::ST_IDLE;
            end
         end
         default: state_in = lld_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         lld_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         lld_pkg::ST_DECODE: cmd.scan_clr = 1'b1;
         lld_pkg::ST_SCAN:   cmd.rd_en    = 1'b1;
         lld_pkg::ST_FETCH: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_use_id = 1'b1;
         end
         lld_pkg::ST_SETTLE: cmd = '0;
         lld_pkg::ST_UPDATE: cmd.upd_en   = !sts.rsp_busy;
         lld_pkg::ST_REPLY:  cmd.reply_en = !sts.rsp_busy;
         default:            cmd = '0;
      endcase
   end

endmodule

### rtl/lld_datapath.sv
module lld_datapath #(
   parameter int MAX_WORKERS = 16,
   parameter int LOAD_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lld_pkg::lld_cmd_type          cmd,
   output lld_pkg::lld_sts_type          sts,
   input  logic [lld_pkg::TDATA_W-1:0]   req_tdata,
   input  logic                          req_tuser,
   input  logic                          csr_wr_en,
   input  logic [lld_pkg::WC_W-1:0]      csr_wr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lld_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic                          rsp_tuser
);

   localparam int AW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CAP = (MAX_WORKERS < 31) ? MAX_WORKERS : 31;
   localparam int EW  = LOAD_WIDTH + 33;
   localparam logic signed [EW-1:0] LMAX =
      signed'({{(EW - LOAD_WIDTH + 1){1'b0}}, {(LOAD_WIDTH - 1){1'b1}}});
   localparam logic signed [EW-1:0] LMIN =
      signed'({{(EW - LOAD_WIDTH + 1){1'b1}}, {(LOAD_WIDTH - 1){1'b0}}});

   logic [lld_pkg::WC_W-1:0]      wc_ff;
   logic                          cmd_ff;
   logic [lld_pkg::AMT_W-1:0]     amt_ff;
   logic [lld_pkg::ID_W-1:0]      id_ff;
   logic [lld_pkg::WC_W-1:0]      cnt_ff;
   logic [lld_pkg::WC_W-1:0]      n_eff;

   logic [LOAD_WIDTH-1:0]         mem [MAX_WORKERS];
   logic [MAX_WORKERS-1:0]        vld_ff;
   logic [LOAD_WIDTH-1:0]         mem_q_ff;
   logic                          vld_q_ff;
   logic                          rd_pend_ff;
   logic                          rd_first_ff;
   logic [lld_pkg::WC_W-1:0]      rd_idx_ff;
   logic [lld_pkg::WC_W-1:0]      rd_src;
   logic [AW-1:0]                 rd_addr;
   logic signed [LOAD_WIDTH-1:0]  rd_data;

   logic signed [LOAD_WIDTH-1:0]  best_ff;
   logic [lld_pkg::WC_W-1:0]      best_idx_ff;
   logic signed [EW-1:0]          cur_x;
   logic signed [EW-1:0]          amt_x;
   logic signed [EW-1:0]          sum_x;
   logic signed [EW-1:0]          dif_x;
   logic signed [LOAD_WIDTH-1:0]  upd_in;

   logic                          rsp_vld_ff;
   logic [lld_pkg::CHOSE_W-1:0]   rsp_chose_ff;
   logic [lld_pkg::OUTL_W-1:0]    rsp_load_ff;
   logic                          rsp_stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff <= lld_pkg::WC_RESET;
      end else if (csr_wr_en) begin
         wc_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (wc_ff == '0) begin
         n_eff = lld_pkg::WC_W'(1);
      end else if (wc_ff > lld_pkg::WC_W'(CAP)) begin
         n_eff = lld_pkg::WC_W'(CAP);
      end else begin
         n_eff = wc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_tuser;
         amt_ff <= req_tdata[lld_pkg::AMT_W-1:0];
         id_ff  <= req_tdata[lld_pkg::AMT_W +: lld_pkg::ID_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         cnt_ff <= '0;
      end else if (cmd.rd_en && !cmd.rd_use_id) begin
         cnt_ff <= cnt_ff + lld_pkg::WC_W'(1);
      end
   end

   assign sts.is_release   = (cmd_ff == lld_pkg::CMD_RELEASE);
   assign sts.id_neg       = id_ff[lld_pkg::ID_W-1];
   assign sts.id_range_err = {1'b0, id_ff[lld_pkg::ID_W-2:0]} >= n_eff;
   assign sts.scan_last    = (cnt_ff == n_eff - lld_pkg::WC_W'(1));
   assign sts.rsp_busy     = rsp_vld_ff && !rsp_tready;

   assign rd_src  = cmd.rd_use_id ? {1'b0, id_ff[lld_pkg::ID_W-2:0]} : cnt_ff;
   assign rd_addr = AW'(rd_src);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
      if (cmd.upd_en) begin
         mem[AW'(best_idx_ff)] <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
         if (cmd.upd_en) begin
            vld_ff[AW'(best_idx_ff)] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         vld_q_ff    <= vld_ff[rd_addr];
         rd_first_ff <= cmd.rd_use_id || (cnt_ff == '0);
         rd_idx_ff   <= rd_src;
      end
   end

   assign rd_data = vld_q_ff ? signed'(mem_q_ff) : '0;

   always_ff @(posedge clock) begin
      if (rd_pend_ff && (rd_first_ff || (best_ff > rd_data))) begin
         best_ff     <= rd_data;
         best_idx_ff <= rd_idx_ff;
      end
   end

   assign cur_x = EW'(best_ff);
   assign amt_x = signed'(EW'(amt_ff));
   assign sum_x = cur_x + amt_x;
   assign dif_x = cur_x - amt_x;

   always_comb begin
      if (cmd_ff == lld_pkg::CMD_DISPATCH) begin
         upd_in = (sum_x > LMAX) ? LOAD_WIDTH'(LMAX) : LOAD_WIDTH'(sum_x);
      end else begin
         upd_in = (dif_x < LMIN) ? LOAD_WIDTH'(LMIN) : LOAD_WIDTH'(dif_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.upd_en || cmd.reply_en) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_en) begin
         rsp_chose_ff <= best_idx_ff[lld_pkg::CHOSE_W-1:0];
         rsp_load_ff  <= lld_pkg::OUTL_W'(upd_in);
         rsp_stat_ff  <= lld_pkg::STATUS_OK;
      end else if (cmd.reply_en) begin
         rsp_chose_ff <= '0;
         rsp_load_ff  <= '0;
         rsp_stat_ff  <= id_ff[lld_pkg::ID_W-1] ? lld_pkg::STATUS_OK : lld_pkg::STATUS_RANGE;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(lld_pkg::TDATA_W - lld_pkg::CHOSE_W - lld_pkg::OUTL_W){1'b0}},
                        rsp_load_ff, rsp_chose_ff};
   assign rsp_tuser  = rsp_stat_ff;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam longint LOAD_MAX = 64'sd2147483647;
   localparam longint LOAD_MIN = -LOAD_MAX - 1;
   localparam int     N_WORKERS = 16;

   typedef struct {
      logic                       is_cfg;
      logic [lld_pkg::WC_W-1:0]   cfg_value;
      logic                       cmd;
      logic [lld_pkg::AMT_W-1:0]  amount;
      logic [lld_pkg::ID_W-1:0]   wid;
      int                         gap;
   } queued_request_type;

   typedef struct packed {
      logic [lld_pkg::CHOSE_W-1:0]       worker;
      logic signed [lld_pkg::OUTL_W-1:0] load;
      logic                              status;
   } reply_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [lld_pkg::TDATA_W-1:0]  req_tdata   = '0;
   logic                         req_tuser   = lld_pkg::CMD_DISPATCH;
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [lld_pkg::TDATA_W-1:0]  rsp_tdata;
   logic                         rsp_tuser;
   logic                         csr_wr_en   = 1'b0;
   logic [lld_pkg::WC_W-1:0]     csr_wr_data = '0;

   queued_request_type  queued_requests[$];
   reply_type           pending_replies[$];

   logic signed [lld_pkg::OUTL_W-1:0] worker_load[N_WORKERS];
   logic [lld_pkg::WC_W-1:0]          pool_size_model = lld_pkg::WC_RESET;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   gap_left = 0;
   logic gap_armed = 1'b0;
   int   stall_left = 0;
   int   calm_left = 0;

   int fail_count = 0;
   int dispatch_count = 0;
   int release_count = 0;
   int noop_count = 0;
   int range_count = 0;
   int saturate_count = 0;
   int config_count = 0;

   least_loaded_worker_dispatch #(
      .MAX_WORKERS(N_WORKERS),
      .LOAD_WIDTH (lld_pkg::OUTL_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int active_workers_of(logic [lld_pkg::WC_W-1:0] value);
      int n;
      n = int'(value);
      if (n == 0) n = 1;
      if (n > N_WORKERS) n = N_WORKERS;
      return n;
   endfunction

   function automatic logic signed [lld_pkg::OUTL_W-1:0] clamp_load(longint total);
      if (total > LOAD_MAX) begin
         saturate_count++;
         return LOAD_MAX[lld_pkg::OUTL_W-1:0];
      end
      if (total < LOAD_MIN) begin
         saturate_count++;
         return LOAD_MIN[lld_pkg::OUTL_W-1:0];
      end
      return total[lld_pkg::OUTL_W-1:0];
   endfunction

   function automatic reply_type apply_request(logic cmd, logic [lld_pkg::AMT_W-1:0] amount,
                                               logic [lld_pkg::ID_W-1:0] wid);
      reply_type r;
      int        n;
      int        best;
      n = active_workers_of(pool_size_model);
      r = '{worker: '0, load: '0, status: lld_pkg::STATUS_OK};
      if (cmd == lld_pkg::CMD_DISPATCH) begin
         dispatch_count++;
         best = 0;
         for (int i = 1; i < n; i++) begin
            if (worker_load[best] > worker_load[i]) best = i;
         end
         worker_load[best] = clamp_load(longint'(worker_load[best]) + longint'(amount));
         r.worker = best[lld_pkg::CHOSE_W-1:0];
         r.load   = worker_load[best];
      end else if (wid[lld_pkg::ID_W-1]) begin
         noop_count++;
      end else if (int'(wid) >= n) begin
         range_count++;
         r.status = lld_pkg::STATUS_RANGE;
      end else begin
         release_count++;
         worker_load[wid] = clamp_load(longint'(worker_load[wid]) - longint'(amount));
         r.worker = wid[lld_pkg::CHOSE_W-1:0];
         r.load   = worker_load[wid];
      end
      return r;
   endfunction

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic queue_request(logic cmd, logic [lld_pkg::AMT_W-1:0] amount,
                                logic [lld_pkg::ID_W-1:0] wid, bit calm);
      queued_request_type q;
      q = '{is_cfg: 1'b0, cfg_value: '0, cmd: cmd, amount: amount, wid: wid,
            gap: draw_gap(calm)};
      queued_requests.push_back(q);
   endtask

   task automatic queue_config(logic [lld_pkg::WC_W-1:0] value);
      queued_request_type q;
      q = '{is_cfg: 1'b1, cfg_value: value, cmd: lld_pkg::CMD_DISPATCH, amount: '0, wid: '0,
            gap: draw_gap(1'b0)};
      queued_requests.push_back(q);
   endtask

   function automatic logic [lld_pkg::AMT_W-1:0] draw_amount();
      case ($urandom_range(0, 9))
         0: return '1;
         1: return '0;
         2: return lld_pkg::AMT_W'($urandom);
         3: return lld_pkg::AMT_W'($urandom);
         4: return lld_pkg::AMT_W'(32'h4000_0000 + $urandom_range(0, 255));
         default: return lld_pkg::AMT_W'($urandom_range(0, 1000));
      endcase
   endfunction

   task automatic queue_random_request(int n, bit calm);
      int                        pick;
      logic [lld_pkg::ID_W-1:0]  wid;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         queue_request(lld_pkg::CMD_DISPATCH, draw_amount(), lld_pkg::ID_W'($urandom), calm);
      end else begin
         if (pick < 85)
            wid = lld_pkg::ID_W'($urandom_range(0, n - 1));
         else if (pick < 93 || n == N_WORKERS)
            wid = lld_pkg::ID_W'(5'h10 | $urandom_range(0, 15));
         else
            wid = lld_pkg::ID_W'($urandom_range(n, N_WORKERS - 1));
         queue_request(lld_pkg::CMD_RELEASE, draw_amount(), wid, calm);
      end
   endtask

   task automatic build_stimulus();
      logic [lld_pkg::WC_W-1:0] phase_counts[10];
      phase_counts = '{5'd16, 5'd1, 5'd2, 5'd17, 5'd31, 5'd0, 5'd8, 5'd15, 5'd0, 5'd0};
      phase_counts[8] = lld_pkg::WC_W'($urandom_range(0, 31));
      phase_counts[9] = lld_pkg::WC_W'($urandom_range(0, 31));

      // default worker count: ties, saturation both ways, no-ops and range errors
      queue_request(lld_pkg::CMD_DISPATCH, '0, '0, 1'b0);
      queue_request(lld_pkg::CMD_DISPATCH, '1, '0, 1'b0);
      queue_request(lld_pkg::CMD_DISPATCH, 31'd5, '0, 1'b0);
      queue_request(lld_pkg::CMD_DISPATCH, '1, '0, 1'b0);
      queue_request(lld_pkg::CMD_DISPATCH, '1, '0, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, '1, 5'd0, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, '1, 5'd0, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, '1, 5'd0, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, '0, 5'd0, 1'b0);
      queue_request(lld_pkg::CMD_DISPATCH, 31'd1, 5'h1f, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, '1, 5'h1f, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, '1, 5'h10, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, 31'd7, 5'd3, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, 31'd7, 5'd15, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, '0, 5'd2, 1'b0);
      // zero worker count behaves as one worker
      queue_config(5'd0);
      queue_request(lld_pkg::CMD_DISPATCH, 31'd9, 5'd4, 1'b0);
      queue_request(lld_pkg::CMD_DISPATCH, 31'd9, 5'd0, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, 31'd3, 5'd1, 1'b0);
      // oversize worker count caps at the table size
      queue_config(5'd31);
      queue_request(lld_pkg::CMD_DISPATCH, 31'd2, 5'd0, 1'b0);
      queue_request(lld_pkg::CMD_RELEASE, 31'd2, 5'd15, 1'b0);
      queue_request(lld_pkg::CMD_DISPATCH, '1, 5'd0, 1'b0);

      for (int p = 0; p < 10; p++) begin
         bit calm;
         calm = (p % 4 == 2);
         queue_config(phase_counts[p]);
         for (int k = 0; k < 125; k++)
            queue_random_request(active_workers_of(phase_counts[p]), calm);
      end
   endtask

   always @(negedge clock) begin
      logic nxt_valid;
      logic nxt_wr;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wr_en  <= 1'b0;
         gap_armed   = 1'b0;
      end else begin
         nxt_valid = req_tvalid && !req_fire;
         nxt_wr    = 1'b0;
         if (!nxt_valid && queued_requests.size() > 0) begin
            if (!gap_armed) begin
               gap_left  = queued_requests[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_requests[0].is_cfg) begin
               if (pending_replies.size() == 0) begin
                  csr_wr_data <= queued_requests[0].cfg_value;
                  nxt_wr    = 1'b1;
                  gap_armed = 1'b0;
                  void'(queued_requests.pop_front());
               end
            end else begin
               req_tuser <= queued_requests[0].cmd;
               req_tdata <= lld_pkg::TDATA_W'({queued_requests[0].wid,
                                               queued_requests[0].amount});
               nxt_valid = 1'b1;
               gap_armed = 1'b0;
               void'(queued_requests.pop_front());
            end
         end
         req_tvalid <= nxt_valid;
         csr_wr_en  <= nxt_wr;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else if (rsp_fire) begin
         if (calm_left > 0) begin
            calm_left--;
            stall_left = 0;
         end else if ($urandom_range(0, 49) == 0) begin
            calm_left  = 30;
            stall_left = 0;
         end else begin
            stall_left = $urandom_range(0, 11);
         end
         rsp_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         for (int i = 0; i < N_WORKERS; i++) worker_load[i] = '0;
         pool_size_model = lld_pkg::WC_RESET;
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (csr_wr_en) begin
            pool_size_model = csr_wr_data;
            config_count++;
         end
         if (req_tvalid && req_tready)
            pending_replies.push_back(apply_request(req_tuser,
               req_tdata[lld_pkg::AMT_W-1:0],
               req_tdata[lld_pkg::AMT_W+lld_pkg::ID_W-1:lld_pkg::AMT_W]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected reply, expected none, got worker %0d load %0d",
                        $time, rsp_tdata[3:0], $signed(rsp_tdata[35:4]));
               fail_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tdata[lld_pkg::CHOSE_W-1:0] !== want.worker) begin
                  $display("%0t: chosen_worker expected %0d got %0d",
                           $time, want.worker, rsp_tdata[lld_pkg::CHOSE_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[lld_pkg::CHOSE_W+lld_pkg::OUTL_W-1:lld_pkg::CHOSE_W]
                   !== want.load) begin
                  $display("%0t: new_load expected %0d got %0d", $time, want.load,
                     $signed(rsp_tdata[lld_pkg::CHOSE_W+lld_pkg::OUTL_W-1:lld_pkg::CHOSE_W]));
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      while (queued_requests.size() > 0 || req_tvalid || pending_replies.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      $display("summary: %0d dispatches, %0d releases, %0d no-op and %0d out-of-range ids",
               dispatch_count, release_count, noop_count, range_count);
      $display("summary: %0d saturated updates across %0d worker-count writes",
               saturate_count, config_count);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d replies outstanding", pending_replies.size());
      $display("testbench: FAIL");
      $finish;
   end

endmodule

### files.f
rtl/lld_pkg.sv
rtl/lld_ctrl.sv
rtl/lld_datapath.sv
rtl/least_loaded_worker_dispatch.sv
test/testbench.sv
